// ===== sv/srsg_pkg.sv =====
// Shared types and constants for the slice RMS silence gate.
// No dependencies; every other file imports this package.
package srsg_pkg;

  // Field and counter widths
  localparam int unsigned CNT_W   = 48;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned SQ_W    = 31;
  localparam int unsigned SUM_W   = 47;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned THR_W   = 31;
  localparam int unsigned HANG_W  = 32;
  localparam int unsigned MIN_W   = 32;
  localparam int unsigned PROD_W  = THR_W + LEN_W;
  localparam int unsigned DISP_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  // Slice queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register reset values
  localparam logic [LEN_W-1:0]  SLICE_LEN_RST = LEN_W'(735);
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(10736763);
  localparam logic [HANG_W-1:0] HANGOVER_RST  = HANG_W'(176400);
  localparam logic [MIN_W-1:0]  MIN_CLIP_RST  = '0;

  typedef enum logic [IDX_W-1:0] {
    REG_SLICE_LEN = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_HANGOVER  = 3'd2,
    REG_MIN_CLIP  = 3'd3
  } cfg_idx_e;

  typedef enum logic [DISP_W-1:0] {
    DISP_IDLE         = 3'd0,
    DISP_START        = 3'd1,
    DISP_CONTINUE     = 3'd2,
    DISP_STOP_KEPT    = 3'd3,
    DISP_STOP_DISCARD = 3'd4
  } disp_e;

  typedef struct packed {
    logic [LEN_W-1:0]  slice_len;
    logic [THR_W-1:0]  threshold;
    logic [HANG_W-1:0] hangover;
    logic [MIN_W-1:0]  min_clip;
  } cfg_t;

  // One closed slice, as handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] n;
    logic [CNT_W-1:0] total;
    logic             eos;
  } slice_t;

endpackage

// ===== sv/srsg_front.sv =====
// Front end: squares each sample and accumulates slices, pushing closed slices.
// Depends on srsg_pkg.
module srsg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          sample_i,
  input  logic                        end_of_stream_i,
  input  logic [srsg_pkg::LEN_W-1:0]  slice_len_i,
  input  logic                        fifo_full_i,
  output logic                        push_o,
  output srsg_pkg::slice_t            push_data_o
);
  import srsg_pkg::*;

  logic              s1_valid_q;
  logic [SQ_W-1:0]   s1_sq_q;
  logic              s1_eos_q;
  logic [SUM_W-1:0]  sum_q;
  logic [LEN_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  tot_q;

  logic signed [31:0] sq_full;
  logic               in_acc;
  logic               s1_go;
  logic [SUM_W-1:0]   sum_new;
  logic [LEN_W-1:0]   cnt_new;
  logic [CNT_W-1:0]   tot_new;
  logic               slice_end;

  // Hold the input while the squared sample cannot move on
  assign s1_go      = s1_valid_q && !fifo_full_i;
  assign in_stall_o = s1_valid_q && fifo_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sq_full    = sample_i * sample_i;

  // Accumulate and detect the slice end
  assign sum_new   = sum_q + SUM_W'(s1_sq_q);
  assign cnt_new   = cnt_q + LEN_W'(1);
  assign tot_new   = tot_q + CNT_W'(1);
  assign slice_end = (cnt_new >= slice_len_i) || s1_eos_q;

  assign push_o            = s1_go && slice_end;
  assign push_data_o.sum   = sum_new;
  assign push_data_o.n     = cnt_new;
  assign push_data_o.total = tot_new;
  assign push_data_o.eos   = s1_eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_sq_q    <= '0;
      s1_eos_q   <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      tot_q      <= '0;
    end else begin
      // Square stage
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_sq_q    <= sq_full[SQ_W-1:0];
        s1_eos_q   <= end_of_stream_i;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      // Accumulate stage; clear the slice on its end, everything on end of stream
      if (s1_go) begin
        if (slice_end) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_new;
          cnt_q <= cnt_new;
        end
        tot_q <= s1_eos_q ? '0 : tot_new;
      end
    end
  end

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_data_o.n != '0))
    else $error("front pushed an empty slice");

endmodule

// ===== sv/srsg_fifo.sv =====
// Short register queue of closed slices between front and back.
// Depends on srsg_pkg.
module srsg_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srsg_pkg::slice_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output srsg_pkg::slice_t  data_o
);
  import srsg_pkg::*;

  slice_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q;
  logic [FIFO_AW-1:0]   rd_ptr_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Write at tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("slice queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("slice queue underflow");

endmodule

// ===== sv/srsg_back.sv =====
// Back end: loudness test per slice, gate machine and output register.
// Depends on srsg_pkg.
module srsg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srsg_pkg::cfg_t              cfg_i,
  input  logic                        fifo_valid_i,
  input  srsg_pkg::slice_t            fifo_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srsg_pkg::DISP_W-1:0] disposition_o,
  output logic [srsg_pkg::LEN_W-1:0]  slice_samples_o,
  output logic [srsg_pkg::CNT_W-1:0]  stream_position_o,
  output logic [srsg_pkg::CNT_W-1:0]  clip_length_o,
  output logic                        run_end_o
);
  import srsg_pkg::*;

  // Product stage
  logic              x_valid_q;
  logic [SUM_W-1:0]  x_sum_q;
  logic [PROD_W-1:0] x_prod_q;
  logic [LEN_W-1:0]  x_n_q;
  logic [CNT_W-1:0]  x_tot_q;
  logic              x_eos_q;

  // Gate state
  logic              rec_q;
  logic              pend_q;
  logic [CNT_W-1:0]  cut_q;
  logic [CNT_W-1:0]  quiet_q;

  // Output register
  logic              out_valid_q;
  disp_e             out_disp_q;
  logic [LEN_W-1:0]  out_n_q;
  logic [CNT_W-1:0]  out_pos_q;
  logic [CNT_W-1:0]  out_clip_q;
  logic              out_run_end_q;

  logic              out_free;
  logic              gate_go;
  logic              loud;
  logic [CNT_W-1:0]  hang_ext;
  logic [CNT_W-1:0]  clip;
  disp_e             stop_disp;
  logic [CNT_W-1:0]  cut_add;
  logic [CNT_W-1:0]  quiet_add;
  disp_e             j_disp;
  logic [CNT_W-1:0]  j_clip;
  logic              rec_j;
  logic [CNT_W-1:0]  cut_j;
  logic [CNT_W-1:0]  quiet_j;

  assign out_free = !out_valid_q || !out_stall_i;
  assign gate_go  = out_free && !pend_q && x_valid_q;
  assign pop_o    = fifo_valid_i && (!x_valid_q || gate_go);

  // Stop length after the hangover cut, and its keep or discard verdict
  assign hang_ext  = CNT_W'(cfg_i.hangover);
  assign clip      = (cut_q > hang_ext) ? (cut_q - hang_ext) : '0;
  assign stop_disp = ((cfg_i.min_clip != '0) && (clip < CNT_W'(cfg_i.min_clip))) ?
                     DISP_STOP_DISCARD : DISP_STOP_KEPT;

  assign loud      = x_sum_q > x_prod_q;
  assign cut_add   = cut_q + CNT_W'(x_n_q);
  assign quiet_add = quiet_q + CNT_W'(x_n_q);

  // Judge one slice
  always_comb begin
    rec_j   = rec_q;
    cut_j   = cut_q;
    quiet_j = quiet_q;
    j_disp  = DISP_IDLE;
    j_clip  = cut_q;
    if (rec_q) begin
      if (quiet_q > hang_ext) begin
        j_disp  = stop_disp;
        j_clip  = clip;
        rec_j   = 1'b0;
        cut_j   = '0;
        quiet_j = '0;
      end else begin
        j_disp  = DISP_CONTINUE;
        j_clip  = cut_add;
        cut_j   = cut_add;
        quiet_j = loud ? '0 : quiet_add;
      end
    end else if (loud) begin
      j_disp = DISP_START;
      rec_j  = 1'b1;
    end
  end

  // Load the product stage from the queue head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      x_sum_q   <= '0;
      x_prod_q  <= '0;
      x_n_q     <= '0;
      x_tot_q   <= '0;
      x_eos_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        x_valid_q <= 1'b1;
        x_sum_q   <= fifo_data_i.sum;
        x_prod_q  <= PROD_W'(cfg_i.threshold) * PROD_W'(fifo_data_i.n);
        x_n_q     <= fifo_data_i.n;
        x_tot_q   <= fifo_data_i.total;
        x_eos_q   <= fifo_data_i.eos;
      end else if (gate_go) begin
        x_valid_q <= 1'b0;
      end
    end
  end

  // Advance the gate and fill the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q         <= 1'b0;
      pend_q        <= 1'b0;
      cut_q         <= '0;
      quiet_q       <= '0;
      out_valid_q   <= 1'b0;
      out_disp_q    <= DISP_IDLE;
      out_n_q       <= '0;
      out_pos_q     <= '0;
      out_clip_q    <= '0;
      out_run_end_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
      if (pend_q) begin
        // Forced stop at end of stream; position stays that of the last slice
        out_valid_q   <= 1'b1;
        out_disp_q    <= stop_disp;
        out_n_q       <= '0;
        out_clip_q    <= clip;
        out_run_end_q <= 1'b1;
        rec_q         <= 1'b0;
        cut_q         <= '0;
        quiet_q       <= '0;
        pend_q        <= 1'b0;
      end else if (x_valid_q) begin
        out_valid_q   <= 1'b1;
        out_disp_q    <= j_disp;
        out_n_q       <= x_n_q;
        out_pos_q     <= x_tot_q;
        out_clip_q    <= j_clip;
        out_run_end_q <= !(x_eos_q && rec_j);
        if (x_eos_q && !rec_j) begin
          rec_q   <= 1'b0;
          cut_q   <= '0;
          quiet_q <= '0;
        end else begin
          rec_q   <= rec_j;
          cut_q   <= cut_j;
          quiet_q <= quiet_j;
          pend_q  <= x_eos_q;
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign disposition_o     = out_disp_q;
  assign slice_samples_o   = out_n_q;
  assign stream_position_o = out_pos_q;
  assign clip_length_o     = out_clip_q;
  assign run_end_o         = out_run_end_q;

  a_pend_recording: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> rec_q)
    else $error("forced stop pending while not recording");

  a_idle_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_q |-> (cut_q == '0 && quiet_q == '0))
    else $error("clip counters not clear while idle");

  a_forced_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_free) |=> (out_valid_q && out_run_end_q && out_n_q == '0 && !rec_q))
    else $error("forced stop not issued as a final empty-slice result");

endmodule

// ===== sv/slice_rms_silence_gate.sv =====
// Top level of the slice RMS silence gate: configuration registers and wiring.
// Depends on srsg_pkg, srsg_front, srsg_fifo and srsg_back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid_i / in_stall_o    | sample_i, end_of_stream_i
//  out      | out_valid_o / out_stall_i  | disposition_o, slice_samples_o,
//           |                            | stream_position_o, clip_length_o, run_end_o
//  cfg      | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One sample is taken per cycle unless in_stall_o holds the input; a slice result is offered once it
// has passed the square reg, accumulation into the queue, the threshold product and the output reg.
// End of stream while recording adds a forced-stop word after the slice's own result.
// The four-entry slice queue lets the front keep accepting while the output stalls, until it fills.
// Reset clears all counters and the gate; registers return to their reset values.
module slice_rms_silence_gate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           sample_i,
  input  logic                         end_of_stream_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [srsg_pkg::DISP_W-1:0]  disposition_o,
  output logic [srsg_pkg::LEN_W-1:0]   slice_samples_o,
  output logic [srsg_pkg::CNT_W-1:0]   stream_position_o,
  output logic [srsg_pkg::CNT_W-1:0]   clip_length_o,
  output logic                         run_end_o,
  input  logic                         cfg_we_i,
  input  logic [srsg_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [srsg_pkg::DATA_W-1:0]  cfg_data_i
);
  import srsg_pkg::*;

  cfg_t   cfg_q;
  logic   push;
  slice_t push_data;
  logic   fifo_full;
  logic   fifo_valid;
  slice_t fifo_data;
  logic   pop;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slice_len <= SLICE_LEN_RST;
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.hangover  <= HANGOVER_RST;
      cfg_q.min_clip  <= MIN_CLIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_SLICE_LEN: cfg_q.slice_len <= cfg_data_i[LEN_W-1:0];
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[THR_W-1:0];
        REG_HANGOVER:  cfg_q.hangover  <= cfg_data_i[HANG_W-1:0];
        REG_MIN_CLIP:  cfg_q.min_clip  <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  srsg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .end_of_stream_i (end_of_stream_i),
    .slice_len_i     (cfg_q.slice_len),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  srsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  srsg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .fifo_valid_i      (fifo_valid),
    .fifo_data_i       (fifo_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .disposition_o     (disposition_o),
    .slice_samples_o   (slice_samples_o),
    .stream_position_o (stream_position_o),
    .clip_length_o     (clip_length_o),
    .run_end_o         (run_end_o)
  );

endmodule
